/* hw/rtl/pol_pkg.sv */
// Package for the positional ordered list: field widths, request and status
// codes, default sizes and the command struct broadcast to the cell row.
// No dependencies.
package pol_pkg;

   localparam int DEPTH_DEFAULT      = 32;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam int REQ_TYPE_WIDTH  = 2;
   localparam int POSITION_WIDTH  = 6;
   localparam int ENTRY_WIDTH     = 32;
   localparam int STATUS_WIDTH    = 2;
   localparam int READ_WIDTH      = 32;
   localparam int COUNT_OUT_WIDTH = 6;

   localparam logic [REQ_TYPE_WIDTH-1:0] REQ_INSERT = 2'd0;
   localparam logic [REQ_TYPE_WIDTH-1:0] REQ_DELETE = 2'd1;
   localparam logic [REQ_TYPE_WIDTH-1:0] REQ_READ   = 2'd2;

   localparam logic [STATUS_WIDTH-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_FULL   = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_EMPTY  = 2'd2;
   localparam logic [STATUS_WIDTH-1:0] ST_BADPOS = 2'd3;

   typedef struct packed {
      logic shift_up;
      logic shift_down;
      logic read_en;
   } pol_cmd_type;

endpackage

/* hw/rtl/pol_if.sv */
// Valid/ready channel interfaces for request and response items.
// Depends on pol_pkg for the field widths.
interface pol_req_if import pol_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [REQ_TYPE_WIDTH-1:0] req_type;
   logic [POSITION_WIDTH-1:0] position;
   logic [ENTRY_WIDTH-1:0]    entry_data;

   modport source (output valid, req_type, position, entry_data, input ready);
   modport sink   (input valid, req_type, position, entry_data, output ready);
endinterface

interface pol_rsp_if import pol_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [STATUS_WIDTH-1:0]    status;
   logic [READ_WIDTH-1:0]      read_data;
   logic [COUNT_OUT_WIDTH-1:0] entry_count;

   modport source (output valid, status, read_data, entry_count, input ready);
   modport sink   (input valid, status, read_data, entry_count, output ready);
endinterface

/* hw/rtl/positional_ordered_list.sv */
// Positional ordered list: a row of DEPTH cells that together hold up to
// DEPTH words, addressed by 1-based position. Insert, delete and read each
// take one item per cycle; the response appears in an output register in the
// cycle after acceptance, and a new request is accepted whenever that
// register is empty or being emptied in the same cycle. An insert or delete
// moves all later entries together, since every cell loads from its neighbor
// at once. Status reports full or empty ahead of an invalid position. There
// is no clearing pass after reset: only the entry count and the response
// valid flag are reset. Depends on pol_pkg, pol_if and pol_cell.
module positional_ordered_list_core
   import pol_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   pol_req_if.sink   req_chan,
   pol_rsp_if.source rsp_chan
);

   localparam int CW     = $clog2(DEPTH + 1);
   localparam int PW     = $clog2(DEPTH);
   localparam int CMP_W  = ((CW > POSITION_WIDTH) ? CW : POSITION_WIDTH) + 1;

   logic [CW-1:0]              count_ff;
   logic [CW-1:0]              count_in;
   logic                       rsp_valid_ff;
   logic [STATUS_WIDTH-1:0]    status_ff;
   logic [STATUS_WIDTH-1:0]    status_in;
   logic [READ_WIDTH-1:0]      rdata_ff;
   logic [READ_WIDTH-1:0]      rdata_in;
   logic [COUNT_OUT_WIDTH-1:0] cnt_out_ff;

   logic                  accept;
   pol_cmd_type           cmd;
   logic [CMP_W-1:0]      pos_ext;
   logic [CMP_W-1:0]      cnt_ext;
   logic [CMP_W-1:0]      cnt_next_ext;
   logic [PW-1:0]         pos_idx;
   logic [DATA_WIDTH-1:0] wr_word;
   logic [DATA_WIDTH-1:0] rd_word;
   logic [DATA_WIDTH-1:0] cell_word [DEPTH];
   logic [DATA_WIDTH-1:0] hit_word  [DEPTH];

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign pos_ext      = CMP_W'(req_chan.position);
   assign cnt_ext      = CMP_W'(count_ff);
   assign cnt_next_ext = CMP_W'(count_in);
   assign pos_idx      = PW'(pos_ext - CMP_W'(1));

   // Stored words are the entry field fitted to the data width, and the
   // response shows the low bits of a stored word.
   generate
      if (DATA_WIDTH <= ENTRY_WIDTH) begin : g_wr_narrow
         assign wr_word = req_chan.entry_data[DATA_WIDTH-1:0];
      end else begin : g_wr_wide
         assign wr_word = {{(DATA_WIDTH - ENTRY_WIDTH){1'b0}}, req_chan.entry_data};
      end
      if (DATA_WIDTH >= READ_WIDTH) begin : g_rd_wide
         assign rdata_in = rd_word[READ_WIDTH-1:0];
      end else begin : g_rd_narrow
         assign rdata_in = {{(READ_WIDTH - DATA_WIDTH){1'b0}}, rd_word};
      end
   endgenerate

   always_comb begin
      cmd       = '0;
      status_in = ST_OK;
      count_in  = count_ff;
      case (req_chan.req_type)
         REQ_INSERT: begin
            if (count_ff == CW'(DEPTH)) begin
               status_in = ST_FULL;
            end else if ((pos_ext == '0) || (pos_ext > (cnt_ext + CMP_W'(1)))) begin
               status_in = ST_BADPOS;
            end else begin
               cmd.shift_up = accept;
               count_in     = count_ff + CW'(1);
            end
         end
         REQ_DELETE, REQ_READ: begin
            if (count_ff == '0) begin
               status_in = ST_EMPTY;
            end else if ((pos_ext == '0) || (pos_ext > cnt_ext)) begin
               status_in = ST_BADPOS;
            end else if (req_chan.req_type == REQ_READ) begin
               cmd.read_en = 1'b1;
            end else begin
               cmd.shift_down = accept;
               count_in       = count_ff - CW'(1);
            end
         end
         default: begin
            status_in = ST_BADPOS;
         end
      endcase
   end

   generate
      for (genvar i = 0; i < DEPTH; i++) begin : g_cell
         logic [DATA_WIDTH-1:0] left_word;
         logic [DATA_WIDTH-1:0] right_word;

         if (i == 0) begin : g_first
            assign left_word = '0;
         end else begin : g_mid_l
            assign left_word = cell_word[i-1];
         end
         if (i == DEPTH - 1) begin : g_last
            assign right_word = cell_word[i];
         end else begin : g_mid_r
            assign right_word = cell_word[i+1];
         end

         pol_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IDX_WIDTH  (PW),
            .INDEX      (i)
         ) u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .pos_idx    (pos_idx),
            .wr_word    (wr_word),
            .left_word  (left_word),
            .right_word (right_word),
            .word_out   (cell_word[i]),
            .hit_word   (hit_word[i])
         );
      end
   endgenerate

   // At most one cell drives a nonzero hit word.
   always_comb begin
      rd_word = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rd_word = rd_word | hit_word[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         status_ff  <= status_in;
         rdata_ff   <= rdata_in;
         cnt_out_ff <= cnt_next_ext[COUNT_OUT_WIDTH-1:0];
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = status_ff;
   assign rsp_chan.read_data   = rdata_ff;
   assign rsp_chan.entry_count = cnt_out_ff;

endmodule

/* hw/rtl/pol_cell.sv */
// One slot of the list. It holds a word and loads from its left neighbor,
// its right neighbor or the new word, as the broadcast command selects.
// Depends on pol_pkg.
module pol_cell
   import pol_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT,
   parameter int IDX_WIDTH  = 5,
   parameter int INDEX      = 0
) (
   input  logic                  clock,
   input  pol_cmd_type           cmd,
   input  logic [IDX_WIDTH-1:0]  pos_idx,
   input  logic [DATA_WIDTH-1:0] wr_word,
   input  logic [DATA_WIDTH-1:0] left_word,
   input  logic [DATA_WIDTH-1:0] right_word,
   output logic [DATA_WIDTH-1:0] word_out,
   output logic [DATA_WIDTH-1:0] hit_word
);

   localparam logic [IDX_WIDTH-1:0] IDX = IDX_WIDTH'(INDEX);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (cmd.shift_up) begin
         if (pos_idx == IDX) begin
            data_in = wr_word;
         end else if (pos_idx < IDX) begin
            data_in = left_word;
         end
      end else if (cmd.shift_down && (pos_idx <= IDX)) begin
         data_in = right_word;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign word_out = data_ff;
   assign hit_word = (cmd.read_en && (pos_idx == IDX)) ? data_ff : '0;

endmodule

/* dv/pol_list_checker.sv */
`timescale 1ns / 1ps
// Checker for the positional ordered list: watches the request and response
// channels, keeps its own copy of the list, and compares every response item.
// Depends on pol_pkg and the channel interfaces in pol_if.
module pol_list_checker
   import pol_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   pol_req_if   req_mon,
   pol_rsp_if   rsp_mon,
   output int   mismatch_count,
   output int   pending_count
);

   typedef struct packed {
      logic [STATUS_WIDTH-1:0]    status;
      logic [READ_WIDTH-1:0]      read_data;
      logic [COUNT_OUT_WIDTH-1:0] entry_count;
   } list_result_type;

   logic [ENTRY_WIDTH-1:0] slots [DEPTH];
   int                     held;
   list_result_type        expected_results [$];

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: %s mismatch, got %0h expected %0h", $realtime, field, got, want);
      mismatch_count++;
   endtask

   // Applies one request to the shadow list and returns the response it earns.
   task automatic predict_list_op(input logic [REQ_TYPE_WIDTH-1:0] kind,
                                  input logic [POSITION_WIDTH-1:0] pos,
                                  input logic [ENTRY_WIDTH-1:0] word,
                                  output list_result_type res);
      res.status    = ST_OK;
      res.read_data = '0;
      case (kind)
         REQ_INSERT: begin
            if (held >= DEPTH) begin
               res.status = ST_FULL;
            end else if (pos == 0 || int'(pos) > held + 1) begin
               res.status = ST_BADPOS;
            end else begin
               for (int i = held; i >= int'(pos); i--) slots[i] = slots[i-1];
               slots[pos-1] = word;
               held++;
            end
         end
         REQ_DELETE, REQ_READ: begin
            if (held == 0) begin
               res.status = ST_EMPTY;
            end else if (pos == 0 || int'(pos) > held) begin
               res.status = ST_BADPOS;
            end else if (kind == REQ_READ) begin
               res.read_data = slots[pos-1];
            end else begin
               for (int i = int'(pos) - 1; i + 1 < held; i++) slots[i] = slots[i+1];
               held--;
            end
         end
         default: begin
            res.status = ST_BADPOS;
         end
      endcase
      res.entry_count = COUNT_OUT_WIDTH'(held);
   endtask

   always @(posedge clock) begin : monitor
      list_result_type want;
      list_result_type fresh;
      if (reset) begin
         held           = 0;
         mismatch_count = 0;
         expected_results.delete();
      end else begin
         // The response seen at this edge always belongs to an earlier request,
         // so it is matched before the request of this edge is predicted.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected response", 32'(rsp_mon.status), 32'hx);
            end else begin
               want = expected_results.pop_front();
               if (rsp_mon.status !== want.status)
                  report_mismatch("status", 32'(rsp_mon.status), 32'(want.status));
               if (rsp_mon.read_data !== want.read_data)
                  report_mismatch("read_data", rsp_mon.read_data, want.read_data);
               if (rsp_mon.entry_count !== want.entry_count)
                  report_mismatch("entry_count", 32'(rsp_mon.entry_count),
                                  32'(want.entry_count));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            predict_list_op(req_mon.req_type, req_mon.position, req_mon.entry_data, fresh);
            expected_results.push_back(fresh);
         end
      end
      pending_count = expected_results.size();
   end

endmodule

/* dv/tb_positional_ordered_list_core.sv */
`timescale 1ns / 1ps
// Testbench top for positional_ordered_list_core: clock, reset, request and
// response stimulus with random gaps, and the final verdict.
// Depends on pol_pkg, pol_if, the block itself and pol_list_checker.
module tb_positional_ordered_list_core;
   import pol_pkg::*;

   localparam int                        DEPTH      = DEPTH_DEFAULT;
   localparam int                        RAND_ITEMS = 1350;
   localparam logic [REQ_TYPE_WIDTH-1:0] REQ_UNUSED = 2'd3;

   logic clock;
   logic reset;
   int   mismatch_count;
   int   pending_count;
   int   level;
   int   req_quiet_left;
   bit   req_busy;
   int   rsp_quiet_left;
   bit   rsp_busy;

   pol_req_if req_chan ();
   pol_rsp_if rsp_chan ();

   positional_ordered_list_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   pol_list_checker #(.DEPTH(DEPTH)) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("positional_ordered_list_core regression: fail");
      $finish;
   end

   // Waits come in stretches: some with random gaps, some with none at all.
   function automatic int draw_wait(inout int quiet_left, inout bit busy);
      if (quiet_left == 0) begin
         quiet_left = $urandom_range(20, 80);
         busy       = ($urandom_range(0, 2) != 0);
      end
      quiet_left--;
      return busy ? $urandom_range(0, 17) : 0;
   endfunction

   task automatic send_request(input logic [REQ_TYPE_WIDTH-1:0] kind,
                               input logic [POSITION_WIDTH-1:0] pos,
                               input logic [ENTRY_WIDTH-1:0] data);
      int gap;
      gap = draw_wait(req_quiet_left, req_busy);
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid      = 1'b1;
      req_chan.req_type   = kind;
      req_chan.position   = pos;
      req_chan.entry_data = data;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      // Track the fill level only to steer positions into the valid range.
      if (kind == REQ_INSERT && level < DEPTH && pos >= 1 && int'(pos) <= level + 1)
         level++;
      else if (kind == REQ_DELETE && level > 0 && pos >= 1 && int'(pos) <= level)
         level--;
   endtask

   // Response side: the receiver stalls for a drawn wait before each item.
   initial begin
      int stall;
      rsp_chan.ready = 1'b0;
      forever begin
         stall = draw_wait(rsp_quiet_left, rsp_busy);
         if (stall > 0) begin
            rsp_chan.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready = 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         @(negedge clock);
      end
   end

   initial begin
      bit                        filling;
      int                        pick;
      logic [REQ_TYPE_WIDTH-1:0] kind;
      logic [POSITION_WIDTH-1:0] pos;
      req_chan.valid      = 1'b0;
      req_chan.req_type   = REQ_INSERT;
      req_chan.position   = '0;
      req_chan.entry_data = '0;
      level               = 0;
      req_quiet_left      = 0;
      rsp_quiet_left      = 0;
      filling             = 1'b1;
      reset               = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: empty list, bad positions, unused request types, front/middle/end inserts, reads and deletes.
      send_request(REQ_READ,   6'd1,  32'h1234_5678);
      send_request(REQ_DELETE, 6'd0,  32'h0);
      send_request(REQ_READ,   6'd63, 32'h0);
      send_request(REQ_UNUSED, 6'd0,  32'hffff_ffff);
      send_request(REQ_INSERT, 6'd0,  32'hffff_ffff);
      send_request(REQ_INSERT, 6'd2,  32'hdead_beef);
      send_request(REQ_INSERT, 6'd1,  32'hffff_ffff);
      send_request(REQ_INSERT, 6'd1,  32'h0000_0000);
      send_request(REQ_INSERT, 6'd3,  32'ha5a5_a5a5);
      send_request(REQ_INSERT, 6'd2,  32'h5a5a_5a5a);
      send_request(REQ_READ,   6'd0,  32'h0);
      send_request(REQ_READ,   6'd5,  32'h0);
      send_request(REQ_READ,   6'd63, 32'h0);
      for (int p = 1; p <= 4; p++) send_request(REQ_READ, POSITION_WIDTH'(p), 32'h0);
      send_request(REQ_DELETE, 6'd5,  32'h0);
      send_request(REQ_DELETE, 6'd2,  32'h0);
      send_request(REQ_DELETE, 6'd3,  32'h0);
      send_request(REQ_READ,   6'd1,  32'h0);
      send_request(REQ_UNUSED, 6'd63, 32'hffff_ffff);
      send_request(REQ_DELETE, 6'd1,  32'h0);
      send_request(REQ_DELETE, 6'd1,  32'h0);
      send_request(REQ_DELETE, 6'd1,  32'h0);

      // Random part: mostly valid requests that sweep the list between empty
      // and full, with some raw noise on the type and position fields.
      for (int n = 0; n < RAND_ITEMS; n++) begin
         if (filling && level == DEPTH && $urandom_range(0, 9) < 3) filling = 1'b0;
         else if (!filling && level == 0 && $urandom_range(0, 9) < 3) filling = 1'b1;
         else if ($urandom_range(0, 49) == 0) filling = !filling;
         if ($urandom_range(0, 99) < 15) begin
            kind = REQ_TYPE_WIDTH'($urandom_range(0, 3));
            pos  = POSITION_WIDTH'($urandom_range(0, 63));
         end else begin
            pick = $urandom_range(0, 9);
            if (pick < 2) kind = REQ_READ;
            else if ((pick < 8) == filling) kind = REQ_INSERT;
            else kind = REQ_DELETE;
            if (kind == REQ_INSERT)
               pos = POSITION_WIDTH'($urandom_range(1, level + 1));
            else
               pos = POSITION_WIDTH'($urandom_range(1, (level > 0) ? level : 1));
         end
         send_request(kind, pos, $urandom);
      end
      req_chan.valid = 1'b0;

      wait (pending_count == 0);
      repeat (5) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("positional_ordered_list_core regression: pass");
      end else begin
         $display("positional_ordered_list_core regression: fail");
      end
      $finish;
   end

endmodule
